### design/sfdf_pkg.sv
package sfdf_pkg;

    // Input number format.
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int INT_W     = VALUE_W - FRAC_BITS;

    // Digit count limits and the widths of the configuration fields.
    localparam int MAX_INT_DIGITS  = 10;
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int NINT_W          = 4;
    localparam int NFRAC_W         = 3;

    // Fraction scaling: magnitude times 10^nfrac, then drop the fraction bits.
    localparam int POW_W    = 20;
    localparam int PROD_W   = VALUE_W + POW_W;
    localparam int SCALED_W = PROD_W - FRAC_BITS;

    // Binary to BCD converter. Only the low BCD_DIGITS decimal digits are kept.
    localparam int BCD_DIGITS    = 6;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int INT_STEPS     = INT_W / BITS_PER_STEP;
    localparam int FRAC_STEPS    = SCALED_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = 4;

    localparam int CHAR_W = 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_POINT   = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        CHAR_MINUS,
        CHAR_DIGIT,
        CHAR_POINT,
        CHAR_NEWLINE
    } char_kind_t;

    typedef struct packed {
        logic              load_in;
        logic              load_frac;
        logic              conv_step;
        logic              emit;
        char_kind_t        kind;
        logic [NINT_W-1:0] digit_pos;
    } cmd_t;

    typedef struct packed {
        logic               neg;
        logic [NINT_W-1:0]  nint;
        logic [NFRAC_W-1:0] nfrac;
        logic               conv_done;
        logic               out_free;
    } status_t;

    function automatic logic [POW_W-1:0] pow10(input logic [NFRAC_W-1:0] n);
        logic [POW_W-1:0] p;
        unique case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            default: p = 20'd1000000;
        endcase
        return p;
    endfunction

endpackage

### design/signed_fixed_decimal_formatter.sv
// Formats a signed Q16.16 beat as ASCII text, one character per output beat.
// The integer part is converted to BCD before the first character is ready; the fraction part
// is converted after the point is emitted, and only when fraction digits are printed.
// A new value is taken once the newline is in the output register.
// Reset (synchronous, aresetn low) empties the output and sets 3 integer, 2 fraction digits.
module signed_fixed_decimal_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic        m_tlast
);

    localparam logic REG_INT_DIGITS  = 1'b0;
    localparam logic REG_FRAC_DIGITS = 1'b1;

    logic [sfdf_pkg::NINT_W-1:0]  int_digits_reg;
    logic [sfdf_pkg::NFRAC_W-1:0] frac_digits_reg;
    logic                         cfg_write;
    logic                         reg_sel;

    sfdf_pkg::cmd_t    cmd;
    sfdf_pkg::status_t status;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_digits_reg  <= 4'd3;
            frac_digits_reg <= 3'd2;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_INT_DIGITS:  int_digits_reg  <= pwdata[sfdf_pkg::NINT_W-1:0];
                REG_FRAC_DIGITS: frac_digits_reg <= pwdata[sfdf_pkg::NFRAC_W-1:0];
                default:         int_digits_reg  <= int_digits_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_INT_DIGITS:  prdata = {28'd0, int_digits_reg};
            REG_FRAC_DIGITS: prdata = {29'd0, frac_digits_reg};
            default:         prdata = '0;
        endcase
    end

    sfdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfdf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_tdata),
        .int_digits  (int_digits_reg),
        .frac_digits (frac_digits_reg),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_char      (m_tdata),
        .m_last      (m_tlast)
    );

endmodule

### design/sfdf_ctrl.sv
module sfdf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sfdf_pkg::status_t status,
    output sfdf_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV_INT,
        ST_SIGN,
        ST_INT_DIG,
        ST_POINT,
        ST_CONV_FRAC,
        ST_FRAC_DIG,
        ST_NEWLINE
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [sfdf_pkg::NINT_W-1:0]     digit_index_reg;
    logic [sfdf_pkg::NINT_W-1:0]     digit_index_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        digit_index_next = digit_index_reg;
        cmd              = '0;
        cmd.kind         = sfdf_pkg::CHAR_DIGIT;
        cmd.digit_pos    = digit_index_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CONV_INT;
                end
            end
            ST_CONV_INT: begin
                if (status.conv_done) begin
                    digit_index_next = status.nint - 4'd1;
                    state_next       = ST_SIGN;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SIGN: begin
                if (!status.neg) begin
                    state_next = ST_INT_DIG;
                end else if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sfdf_pkg::CHAR_MINUS;
                    state_next = ST_INT_DIG;
                end
            end
            ST_INT_DIG: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (digit_index_reg == '0) begin
                        state_next = ST_POINT;
                    end else begin
                        digit_index_next = digit_index_reg - 4'd1;
                    end
                end
            end
            ST_POINT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = sfdf_pkg::CHAR_POINT;
                    cmd.load_frac = 1'b1;
                    if (status.nfrac == '0) begin
                        state_next = ST_NEWLINE;
                    end else begin
                        state_next = ST_CONV_FRAC;
                    end
                end
            end
            ST_CONV_FRAC: begin
                if (status.conv_done) begin
                    digit_index_next = {1'b0, status.nfrac} - 4'd1;
                    state_next       = ST_FRAC_DIG;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_FRAC_DIG: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (digit_index_reg == '0) begin
                        state_next = ST_NEWLINE;
                    end else begin
                        digit_index_next = digit_index_reg - 4'd1;
                    end
                end
            end
            ST_NEWLINE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sfdf_pkg::CHAR_NEWLINE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            digit_index_reg <= '0;
        end else begin
            state_reg       <= state_next;
            digit_index_reg <= digit_index_next;
        end
    end

endmodule

### design/sfdf_datapath.sv
module sfdf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sfdf_pkg::VALUE_W-1:0]        s_value,
    input  logic [sfdf_pkg::NINT_W-1:0]         int_digits,
    input  logic [sfdf_pkg::NFRAC_W-1:0]        frac_digits,
    input  sfdf_pkg::cmd_t                      cmd,
    output sfdf_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfdf_pkg::CHAR_W-1:0]         m_char,
    output logic                                m_last
);

    logic                                 neg_reg;
    logic [sfdf_pkg::VALUE_W-1:0]         mag_reg;
    logic [sfdf_pkg::NINT_W-1:0]          nint_reg;
    logic [sfdf_pkg::NFRAC_W-1:0]         nfrac_reg;
    logic [sfdf_pkg::SCALED_W-1:0]        scaled_reg;
    logic [sfdf_pkg::SCALED_W-1:0]        src_reg;
    logic [sfdf_pkg::BCD_W-1:0]           bcd_reg;
    logic [sfdf_pkg::STEP_CNT_W-1:0]      steps_reg;
    logic                                 tvalid_reg;
    logic [sfdf_pkg::CHAR_W-1:0]          char_reg;
    logic                                 last_reg;

    logic                                 in_neg;
    logic [sfdf_pkg::VALUE_W-1:0]         in_mag;
    logic [sfdf_pkg::NINT_W-1:0]          nint_sat;
    logic [sfdf_pkg::NFRAC_W-1:0]         nfrac_sat;
    logic [sfdf_pkg::PROD_W-1:0]          prod;
    logic [sfdf_pkg::SCALED_W-1:0]        src_next;
    logic [sfdf_pkg::BCD_W-1:0]           bcd_next;
    logic [3:0]                           digit;
    logic [sfdf_pkg::CHAR_W-1:0]          char_sel;

    // The magnitude of the most negative input is 2^31, which still fits unsigned.
    assign in_neg = s_value[sfdf_pkg::VALUE_W-1];
    assign in_mag = in_neg ? (~s_value + 32'd1) : s_value;

    always_comb begin
        if (int_digits == '0) begin
            nint_sat = 4'd1;
        end else if (int_digits > 4'(sfdf_pkg::MAX_INT_DIGITS)) begin
            nint_sat = 4'(sfdf_pkg::MAX_INT_DIGITS);
        end else begin
            nint_sat = int_digits;
        end
        if (frac_digits > 3'(sfdf_pkg::MAX_FRAC_DIGITS)) begin
            nfrac_sat = 3'(sfdf_pkg::MAX_FRAC_DIGITS);
        end else begin
            nfrac_sat = frac_digits;
        end
    end

    assign prod = sfdf_pkg::PROD_W'(mag_reg) *
                  sfdf_pkg::PROD_W'(sfdf_pkg::pow10(nfrac_reg));

    // Shift-and-add-3 conversion, several source bits per cycle. Digits above
    // the kept ones are dropped, which leaves the value modulo 10^BCD_DIGITS.
    always_comb begin
        bcd_next = bcd_reg;
        src_next = src_reg;
        for (int j = 0; j < sfdf_pkg::BITS_PER_STEP; j++) begin
            for (int d = 0; d < sfdf_pkg::BCD_DIGITS; d++) begin
                if (bcd_next[d*4 +: 4] >= 4'd5) begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[sfdf_pkg::BCD_W-2:0], src_next[sfdf_pkg::SCALED_W-1]};
            src_next = {src_next[sfdf_pkg::SCALED_W-2:0], 1'b0};
        end
    end

    // Positions above the kept digits always print as zero.
    always_comb begin
        digit = 4'd0;
        for (int d = 0; d < sfdf_pkg::BCD_DIGITS; d++) begin
            if (cmd.digit_pos == 4'(d)) begin
                digit = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb begin
        unique case (cmd.kind)
            sfdf_pkg::CHAR_MINUS:   char_sel = sfdf_pkg::ASCII_MINUS;
            sfdf_pkg::CHAR_DIGIT:   char_sel = sfdf_pkg::ASCII_ZERO | {4'd0, digit};
            sfdf_pkg::CHAR_POINT:   char_sel = sfdf_pkg::ASCII_POINT;
            sfdf_pkg::CHAR_NEWLINE: char_sel = sfdf_pkg::ASCII_NEWLINE;
            default:                char_sel = sfdf_pkg::ASCII_NEWLINE;
        endcase
    end

    always_ff @(posedge aclk) begin
        scaled_reg <= prod[sfdf_pkg::PROD_W-1:sfdf_pkg::FRAC_BITS];
        if (cmd.load_in) begin
            neg_reg   <= in_neg;
            mag_reg   <= in_mag;
            nint_reg  <= nint_sat;
            nfrac_reg <= nfrac_sat;
            src_reg   <= {in_mag[sfdf_pkg::VALUE_W-1:sfdf_pkg::FRAC_BITS],
                          (sfdf_pkg::SCALED_W - sfdf_pkg::INT_W)'(0)};
            bcd_reg   <= '0;
        end else if (cmd.load_frac) begin
            src_reg <= scaled_reg;
            bcd_reg <= '0;
        end else if (cmd.conv_step) begin
            src_reg <= src_next;
            bcd_reg <= bcd_next;
        end
        if (cmd.emit) begin
            char_reg <= char_sel;
            last_reg <= (cmd.kind == sfdf_pkg::CHAR_NEWLINE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg  <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                steps_reg <= sfdf_pkg::STEP_CNT_W'(sfdf_pkg::INT_STEPS);
            end else if (cmd.load_frac) begin
                steps_reg <= sfdf_pkg::STEP_CNT_W'(sfdf_pkg::FRAC_STEPS);
            end else if (cmd.conv_step) begin
                steps_reg <= steps_reg - 4'd1;
            end
            if (cmd.emit) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.neg       = neg_reg;
    assign status.nint      = nint_reg;
    assign status.nfrac     = nfrac_reg;
    assign status.conv_done = (steps_reg == '0);
    assign status.out_free  = !tvalid_reg || m_tready;

    assign m_tvalid = tvalid_reg;
    assign m_char   = char_reg;
    assign m_last   = last_reg;

endmodule

### tb/signed_fixed_decimal_formatter_tb.sv
module signed_fixed_decimal_formatter_tb;

    localparam logic [2:0] ADDR_INT_DIGITS  = 3'd0;
    localparam logic [2:0] ADDR_FRAC_DIGITS = 3'd4;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 30;
    localparam int RANDOM_PHASES     = 8;
    localparam int VALUES_PER_PHASE  = 24;
    localparam int MAX_PRINTED_ERRORS = 40;

    typedef struct {
        logic [sfdf_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] char_out
    logic        m_tlast;

    logic [31:0]  pending_values [$];
    text_char_t   text_expect_q [$];
    logic [sfdf_pkg::NINT_W-1:0]  fmt_int_digits  = 4'd3;
    logic [sfdf_pkg::NFRAC_W-1:0] fmt_frac_digits = 3'd2;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int chars_seen = 0;
    int cycles = 0;

    signed_fixed_decimal_formatter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned pow_ten(input int n);
        longint unsigned r;
        r = 1;
        repeat (n) r = r * 10;
        return r;
    endfunction

    function automatic void push_char(input logic [sfdf_pkg::CHAR_W-1:0] ch, input logic last);
        text_char_t c;
        c.ch = ch;
        c.last = last;
        text_expect_q.push_back(c);
    endfunction

    // Most significant digit first, leading zeros kept.
    function automatic void push_digits(input longint unsigned num, input int n);
        for (int p = n - 1; p >= 0; p--)
            push_char(sfdf_pkg::ASCII_ZERO + sfdf_pkg::CHAR_W'((num / pow_ten(p)) % 10),
                      1'b0);
    endfunction

    function automatic void format_value(input logic [31:0] v);
        logic neg;
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned scaled;
        int nint;
        int nfrac;
        neg = v[31];
        mag = neg ? (64'h1_0000_0000 - 64'(v)) : 64'(v);
        nint = int'(fmt_int_digits);
        nfrac = int'(fmt_frac_digits);
        if (nint < 1) nint = 1;
        if (nint > sfdf_pkg::MAX_INT_DIGITS) nint = sfdf_pkg::MAX_INT_DIGITS;
        if (nfrac > sfdf_pkg::MAX_FRAC_DIGITS) nfrac = sfdf_pkg::MAX_FRAC_DIGITS;
        whole = mag >> sfdf_pkg::FRAC_BITS;
        scaled = (mag * pow_ten(nfrac)) >> sfdf_pkg::FRAC_BITS;
        if (neg)
            push_char(sfdf_pkg::ASCII_MINUS, 1'b0);
        push_digits(whole, nint);
        push_char(sfdf_pkg::ASCII_POINT, 1'b0);
        push_digits(scaled, nfrac);
        push_char(sfdf_pkg::ASCII_NEWLINE, 1'b1);
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int sel;
        sel = $urandom_range(3);
        case (sel)
            0: v = $urandom;
            1: begin
                v = {16'($urandom_range(999)), 16'($urandom)};
                if ($urandom_range(1)) v = -v;
            end
            2: v = {($urandom_range(1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
            default: begin
                v = 32'($urandom_range(32'h3FFFF));
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED_ERRORS)
            $display("mismatch at char %0d: %s", chars_seen, msg);
    endtask

    // Input beat driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_values.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predicts text for each accepted value and checks every output beat.
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                format_value(s_tdata);
            if (m_tvalid === 1'b1 && m_tready) begin
                if (text_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat char=%h last=%b",
                                              m_tdata, m_tlast));
                end else begin
                    want = text_expect_q.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("char %h, want %h", m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                end
                chars_seen <= chars_seen + 1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper bits of the write data are random; only the field width counts.
    task automatic set_format(input int nint, input int nfrac);
        write_reg(ADDR_INT_DIGITS, ($urandom & ~32'hF) | 32'(nint & 'hF));
        write_reg(ADDR_FRAC_DIGITS, ($urandom & ~32'h7) | 32'(nfrac & 'h7));
        fmt_int_digits = sfdf_pkg::NINT_W'(nint);
        fmt_frac_digits = sfdf_pkg::NFRAC_W'(nfrac);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    // Sampled at the falling edge, after all beats of the rising edge have settled.
    task automatic drain();
        do
            @(negedge aclk);
        while (pending_values.size() != 0 || s_tvalid || text_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset format: three integer digits, two fraction digits.
        set_idling(0);
        @(negedge aclk);
        pending_values = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
                           32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0C0D_8000};
        drain();

        // Zero integer digits acts as one; fraction count above the limit saturates.
        set_format(0, 7);
        set_idling(1);
        @(negedge aclk);
        pending_values = '{32'h0003_243F, 32'hFFFC_DBC1, 32'h7FFF_FFFF, 32'h8000_0000};
        drain();

        // Integer count above the limit saturates; no fraction digits, point still shown.
        set_format(15, 0);
        set_idling(2);
        @(negedge aclk);
        pending_values = '{32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000};
        drain();

        set_format(10, 6);
        set_idling(3);
        @(negedge aclk);
        pending_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                           32'h1234_5678};
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_format(1, 0);
                1: set_format(10, 6);
                default: set_format($urandom_range(15), $urandom_range(7));
            endcase
            set_idling(ph);
            @(negedge aclk);
            for (int i = 0; i < VALUES_PER_PHASE; i++)
                pending_values.push_back(random_value());
            drain();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
